// File: sv/ffla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared types and constants for the frame free-list allocator.
// ----------------------------------------------------------------------------
package ffla_pkg;

	localparam int FRAMES     = 1024;
	localparam int PAGE_BYTES = 4096;
	localparam int IDX_W      = 10;
	localparam int PTR_W      = 11;
	localparam int OWN_W      = 16;
	localparam int ADDR_W     = 48;

	localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(FRAMES);
	localparam logic [PTR_W-1:0] TOTAL_MAX = 11'd2047;

	typedef enum logic [2:0] {
		FN_INIT    = 3'd0,
		FN_ALLOC   = 3'd1,
		FN_FREE    = 3'd2,
		FN_COUNT   = 3'd3,
		FN_RECLAIM = 3'd4,
		FN_ADDR    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		REG_POOL_COUNT   = 2'd0,
		REG_POOL_BASE    = 2'd1,
		REG_OWNER_NONE   = 2'd2,
		REG_OWNER_KERNEL = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RMW,
		ST_INIT,
		ST_SWEEP,
		ST_ADDR,
		ST_DONE
	} state_t;

endpackage

// File: sv/frame_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_free_list_allocator_core
// Page-frame allocator: LIFO free list and owner tag per frame, held in
// two synchronous memories with registered reads.
// ----------------------------------------------------------------------------
// Usage:
//  Request channel (in_valid/in_ready) carries func, owner_tag, frame_index.
//  Response channel (out_valid/out_ready) returns status, result_frame,
//  tally and phys_address, one response per request, in order.
//  Config channel (cfg_valid/cfg_ready) writes pool_count, pool_base,
//  owner_none, owner_kernel by index; always ready.
//  One request is in flight at a time. Alloc and free read the frame
//  store, then modify and write it back. Init and count/reclaim walk
//  the first n entries of the frame store one entry per cycle, where n
//  is the effective pool count.
//  After reset every frame store entry is cleared; no request is
//  taken during that pass. The free list starts empty.
//  A finished response waits in an output register while the receiver
//  stalls; the next request is accepted meanwhile but its response waits
//  until the register is free.
// ----------------------------------------------------------------------------
module frame_free_list_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [15:0] owner_tag,
	input  logic [9:0]  frame_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [9:0]  result_frame,
	output logic [10:0] tally,
	output logic [47:0] phys_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int SW = ffla_pkg::OWN_W + 1;

	ffla_pkg::state_t state_q, state_d;

	logic [ffla_pkg::PTR_W-1:0]  pool_count_q;
	logic [ffla_pkg::ADDR_W-1:0] pool_base_q;
	logic [ffla_pkg::OWN_W-1:0]  owner_none_q, owner_kernel_q;
	logic [ffla_pkg::PTR_W-1:0]  head_q, total_q;
	logic [2:0]                  func_q;
	logic [ffla_pkg::OWN_W-1:0]  owner_q;
	logic [ffla_pkg::IDX_W-1:0]  idx_q;
	logic [ffla_pkg::PTR_W-1:0]  rd_idx_q;
	logic                        vld_s1;
	logic [ffla_pkg::IDX_W-1:0]  idx_s1;
	logic [ffla_pkg::PTR_W-1:0]  tally_q;
	logic [ffla_pkg::ADDR_W-1:0] prod_q;
	logic                        res_status_q;
	logic [ffla_pkg::IDX_W-1:0]  res_frame_q;
	logic [ffla_pkg::ADDR_W-1:0] res_addr_q;
	logic                        out_valid_q, status_q;
	logic [ffla_pkg::IDX_W-1:0]  frame_q;
	logic [ffla_pkg::PTR_W-1:0]  tally_out_q;
	logic [ffla_pkg::ADDR_W-1:0] addr_q;

	logic [SW-1:0]              st_mem [ffla_pkg::FRAMES];
	logic [ffla_pkg::PTR_W-1:0] lk_mem [ffla_pkg::FRAMES];
	logic [SW-1:0]              st_rd, st_wd;
	logic [ffla_pkg::PTR_W-1:0] lk_rd, lk_wd;
	logic                       st_we, lk_we;
	logic [ffla_pkg::IDX_W-1:0] st_wa, lk_wa, rd_addr;

	logic [ffla_pkg::PTR_W-1:0] n_live;
	logic                       in_xfer, out_free, rd_issue;
	logic                       alloc_ok, free_ok, sweep_hit;
	logic [ffla_pkg::PTR_W-1:0] next_idx, total_inc;

	assign n_live    = (pool_count_q > ffla_pkg::NULL_PTR) ? ffla_pkg::NULL_PTR : pool_count_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign next_idx  = rd_idx_q + 11'd1;
	assign total_inc = (total_q < ffla_pkg::TOTAL_MAX) ? total_q + 11'd1 : total_q;
	assign rd_issue  = (state_q == ffla_pkg::ST_SWEEP) && (rd_idx_q < n_live);

	assign alloc_ok  = !st_rd[SW-1] && (st_rd[SW-2:0] == owner_none_q);
	assign free_ok   = st_rd[SW-1] &&
	                   ((st_rd[SW-2:0] == owner_q) || (owner_q == owner_kernel_q));
	assign sweep_hit = vld_s1 && st_rd[SW-1] && (st_rd[SW-2:0] == owner_q);

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_frame = frame_q;
	assign tally        = tally_out_q;
	assign phys_address = addr_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffla_pkg::ST_CLEAR: begin
				if (rd_idx_q == ffla_pkg::NULL_PTR - 11'd1) state_d = ffla_pkg::ST_IDLE;
			end
			ffla_pkg::ST_IDLE: begin
				if (in_xfer) state_d = ffla_pkg::ST_EXEC;
			end
			ffla_pkg::ST_EXEC: begin
				case (func_q)
					ffla_pkg::FN_INIT:
						state_d = (n_live == '0) ? ffla_pkg::ST_DONE : ffla_pkg::ST_INIT;
					ffla_pkg::FN_ALLOC:
						state_d = (owner_q == owner_none_q || head_q >= n_live) ?
						          ffla_pkg::ST_DONE : ffla_pkg::ST_RMW;
					ffla_pkg::FN_FREE:
						state_d = ({1'b0, idx_q} >= n_live) ? ffla_pkg::ST_DONE : ffla_pkg::ST_RMW;
					ffla_pkg::FN_COUNT, ffla_pkg::FN_RECLAIM:
						state_d = (owner_q == owner_none_q) ? ffla_pkg::ST_DONE : ffla_pkg::ST_SWEEP;
					ffla_pkg::FN_ADDR:
						state_d = ({1'b0, idx_q} >= n_live) ? ffla_pkg::ST_DONE : ffla_pkg::ST_ADDR;
					default: state_d = ffla_pkg::ST_DONE;
				endcase
			end
			ffla_pkg::ST_RMW:  state_d = ffla_pkg::ST_DONE;
			ffla_pkg::ST_ADDR: state_d = ffla_pkg::ST_DONE;
			ffla_pkg::ST_INIT: begin
				if (next_idx == n_live) state_d = ffla_pkg::ST_DONE;
			end
			ffla_pkg::ST_SWEEP: begin
				if (rd_idx_q >= n_live && !vld_s1) state_d = ffla_pkg::ST_DONE;
			end
			ffla_pkg::ST_DONE: begin
				if (out_free) state_d = ffla_pkg::ST_IDLE;
			end
			default: state_d = ffla_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready = (state_q == ffla_pkg::ST_IDLE);
		st_we    = 1'b0;
		st_wa    = rd_idx_q[ffla_pkg::IDX_W-1:0];
		st_wd    = {1'b0, owner_none_q};
		lk_we    = 1'b0;
		lk_wa    = rd_idx_q[ffla_pkg::IDX_W-1:0];
		lk_wd    = head_q;
		rd_addr  = rd_idx_q[ffla_pkg::IDX_W-1:0];
		case (state_q)
			ffla_pkg::ST_CLEAR: begin
				st_we = 1'b1;
				st_wd = '0;
			end
			ffla_pkg::ST_EXEC: begin
				rd_addr = (func_q == ffla_pkg::FN_ALLOC) ? head_q[ffla_pkg::IDX_W-1:0] : idx_q;
			end
			ffla_pkg::ST_INIT: begin
				st_we = 1'b1;
				lk_we = 1'b1;
				lk_wd = (next_idx < n_live) ? next_idx : ffla_pkg::NULL_PTR;
			end
			ffla_pkg::ST_RMW: begin
				if (func_q == ffla_pkg::FN_ALLOC) begin
					st_we = alloc_ok;
					st_wa = head_q[ffla_pkg::IDX_W-1:0];
					st_wd = {1'b1, owner_q};
				end else begin
					st_we = free_ok;
					st_wa = idx_q;
					lk_we = free_ok;
					lk_wa = idx_q;
				end
			end
			ffla_pkg::ST_SWEEP: begin
				st_we = sweep_hit && (func_q == ffla_pkg::FN_RECLAIM);
				st_wa = idx_s1;
				lk_we = st_we;
				lk_wa = idx_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		st_rd <= st_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lk_we) lk_mem[lk_wa] <= lk_wd;
		lk_rd <= lk_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ffla_pkg::ST_CLEAR;
			pool_count_q   <= 11'd1024;
			pool_base_q    <= '0;
			owner_none_q   <= 16'd0;
			owner_kernel_q <= 16'd1;
			head_q         <= ffla_pkg::NULL_PTR;
			total_q        <= '0;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ffla_pkg::REG_POOL_COUNT:   pool_count_q   <= cfg_data[10:0];
					ffla_pkg::REG_POOL_BASE:    pool_base_q    <= cfg_data;
					ffla_pkg::REG_OWNER_NONE:   owner_none_q   <= cfg_data[15:0];
					ffla_pkg::REG_OWNER_KERNEL: owner_kernel_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == ffla_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			vld_s1 <= rd_issue;
			case (state_q)
				ffla_pkg::ST_CLEAR: rd_idx_q <= next_idx;
				ffla_pkg::ST_EXEC: begin
					rd_idx_q <= '0;
					if (func_q == ffla_pkg::FN_INIT && n_live == '0) begin
						head_q  <= ffla_pkg::NULL_PTR;
						total_q <= '0;
					end
				end
				ffla_pkg::ST_INIT: begin
					rd_idx_q <= next_idx;
					if (next_idx == n_live) begin
						head_q  <= '0;
						total_q <= n_live;
					end
				end
				ffla_pkg::ST_RMW: begin
					if (func_q == ffla_pkg::FN_ALLOC) begin
						if (alloc_ok) begin
							head_q  <= lk_rd;
							total_q <= (total_q != '0) ? total_q - 11'd1 : total_q;
						end
					end else if (free_ok) begin
						head_q  <= {1'b0, idx_q};
						total_q <= total_inc;
					end
				end
				ffla_pkg::ST_SWEEP: begin
					if (rd_issue) rd_idx_q <= next_idx;
					if (sweep_hit && func_q == ffla_pkg::FN_RECLAIM) begin
						head_q  <= {1'b0, idx_s1};
						total_q <= total_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[ffla_pkg::IDX_W-1:0];
		case (state_q)
			ffla_pkg::ST_IDLE: begin
				func_q  <= func;
				owner_q <= owner_tag;
				idx_q   <= frame_index;
			end
			ffla_pkg::ST_EXEC: begin
				tally_q     <= '0;
				res_frame_q <= '0;
				res_addr_q  <= '0;
				prod_q      <= ffla_pkg::ADDR_W'({38'd0, idx_q} *
				               ffla_pkg::ADDR_W'(ffla_pkg::PAGE_BYTES));
				case (func_q)
					ffla_pkg::FN_INIT:    res_status_q <= (n_live == '0);
					ffla_pkg::FN_ALLOC:   res_status_q <= 1'b1;
					ffla_pkg::FN_FREE:    res_status_q <= 1'b1;
					ffla_pkg::FN_COUNT,
					ffla_pkg::FN_RECLAIM: res_status_q <= 1'b0;
					ffla_pkg::FN_ADDR:    res_status_q <= ({1'b0, idx_q} >= n_live);
					default:              res_status_q <= 1'b1;
				endcase
			end
			ffla_pkg::ST_RMW: begin
				if (func_q == ffla_pkg::FN_ALLOC) begin
					res_status_q <= !alloc_ok;
					if (alloc_ok) res_frame_q <= head_q[ffla_pkg::IDX_W-1:0];
				end else begin
					res_status_q <= !free_ok;
				end
			end
			ffla_pkg::ST_ADDR: res_addr_q <= pool_base_q + prod_q;
			ffla_pkg::ST_SWEEP: begin
				if (sweep_hit) tally_q <= tally_q + 11'd1;
			end
			ffla_pkg::ST_DONE: begin
				if (out_free) begin
					status_q    <= res_status_q;
					frame_q     <= res_frame_q;
					tally_out_q <= tally_q;
					addr_q      <= res_addr_q;
				end
			end
			default: ;
		endcase
	end

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffla_pkg::ST_CLEAR) |-> !in_ready)
		else $error("request taken during clearing pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("second request taken while busy");

	a_no_stray_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffla_pkg::ST_IDLE) |-> !vld_s1)
		else $error("sweep read pending while idle");

	a_head_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && state_q == ffla_pkg::ST_SWEEP) |=> (head_q == {1'b0, $past(idx_s1)}))
		else $error("reclaimed frame not pushed to head");

endmodule

// File: dv/tb_frame_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_free_list_allocator_core
// Self-checking bench for the frame allocator. A directed table covers the
// empty-list, reserved-code and zero-pool cases, register
// extremes and address wrap. Random phases then rebuild the pool under
// changing registers and mix alloc, free, count, reclaim and address requests,
// with bursty request traffic and a stalling response side. Each response is
// checked against its row or an in-bench model of frame store and free list.
// ----------------------------------------------------------------------------
module tb_frame_free_list_allocator_core;

	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;
	localparam int ROW_ITEM = 0;
	localparam int ROW_CFG  = 1;

	typedef struct packed {
		logic        status;
		logic [9:0]  frame;
		logic [10:0] tally;
		logic [47:0] phys;
	} resp_t;

	typedef struct {
		int                 kind;
		logic [2:0]         fn;
		logic [15:0]        owner;
		logic [9:0]         idx;
		ffla_pkg::reg_idx_t reg_sel;
		logic [47:0]        data;
		bit                 typed;
		resp_t              exp_resp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [15:0] owner_tag;
	logic [9:0]  frame_index;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [9:0]  result_frame;
	logic [10:0] tally;
	logic [47:0] phys_address;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;

	frame_free_list_allocator_core u_dut (.*);

	// allocator state mirror
	bit          used_m [ffla_pkg::FRAMES];
	logic [15:0] owner_m [ffla_pkg::FRAMES];
	int          link_m [ffla_pkg::FRAMES];
	int          head_m;
	logic [10:0] pool_n;
	logic [47:0] base_m;
	logic [15:0] none_m;
	logic [15:0] kern_m;

	resp_t       resp_q[$];
	bit          cur_typed;
	resp_t       cur_exp;
	int          errors;
	int          burst_left;
	logic [15:0] owner_pool [4];
	row_t        rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int live_n();
		return (pool_n > ffla_pkg::FRAMES) ? ffla_pkg::FRAMES : int'(pool_n);
	endfunction

	function automatic void free_frame(int i);
		used_m[i]  = 1'b0;
		owner_m[i] = none_m;
		link_m[i]  = head_m;
		head_m     = i;
	endfunction

	function automatic resp_t apply_request(logic [2:0] f, logic [15:0] o, logic [9:0] ix);
		resp_t r;
		int n;
		int h;
		r = '0;
		n = live_n();
		case (f)
			ffla_pkg::FN_INIT: begin
				if (n == 0) begin
					head_m = ffla_pkg::FRAMES;
					r.status = 1'b1;
				end else begin
					for (int i = 0; i < n; i++) begin
						used_m[i]  = 1'b0;
						owner_m[i] = none_m;
						link_m[i]  = (i + 1 < n) ? i + 1 : ffla_pkg::FRAMES;
					end
					head_m = 0;
				end
			end
			ffla_pkg::FN_ALLOC: begin
				h = head_m;
				if (o == none_m || h >= n || used_m[h] || owner_m[h] != none_m) begin
					r.status = 1'b1;
				end else begin
					head_m     = link_m[h];
					owner_m[h] = o;
					used_m[h]  = 1'b1;
					r.frame    = h[9:0];
				end
			end
			ffla_pkg::FN_FREE: begin
				if (int'(ix) >= n || !used_m[ix] || (owner_m[ix] != o && o != kern_m))
					r.status = 1'b1;
				else
					free_frame(int'(ix));
			end
			ffla_pkg::FN_COUNT, ffla_pkg::FN_RECLAIM: begin
				if (o != none_m) begin
					for (int i = 0; i < n; i++) begin
						if (used_m[i] && owner_m[i] == o) begin
							if (f == ffla_pkg::FN_RECLAIM)
								free_frame(i);
							r.tally++;
						end
					end
				end
			end
			ffla_pkg::FN_ADDR: begin
				if (int'(ix) >= n)
					r.status = 1'b1;
				else
					r.phys = base_m + 48'(ix) * 48'(ffla_pkg::PAGE_BYTES);
			end
			default: r.status = 1'b1;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		resp_t p;
		resp_t e;
		if (cfg_valid && cfg_ready) begin
			case (ffla_pkg::reg_idx_t'(cfg_index))
				ffla_pkg::REG_POOL_COUNT:   pool_n = cfg_data[10:0];
				ffla_pkg::REG_POOL_BASE:    base_m = cfg_data;
				ffla_pkg::REG_OWNER_NONE:   none_m = cfg_data[15:0];
				ffla_pkg::REG_OWNER_KERNEL: kern_m = cfg_data[15:0];
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			p = apply_request(func, owner_tag, frame_index);
			resp_q.push_back(cur_typed ? cur_exp : p);
		end
		if (out_valid && out_ready) begin
			if (resp_q.size() == 0) begin
				report_mismatch("response with nothing pending");
			end else begin
				e = resp_q.pop_front();
				if (status !== e.status)
					report_mismatch($sformatf("status %0d exp %0d", status, e.status));
				if (result_frame !== e.frame)
					report_mismatch($sformatf("frame %0d exp %0d", result_frame, e.frame));
				if (tally !== e.tally)
					report_mismatch($sformatf("tally %0d exp %0d", tally, e.tally));
				if (phys_address !== e.phys)
					report_mismatch($sformatf("addr %0h exp %0h", phys_address, e.phys));
			end
		end
	end

	// response-side stall pattern
	initial begin
		int mode;
		int left;
		out_ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 96);
			end
			left--;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = $urandom_range(0, 1);
				2: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = ($urandom_range(0, 19) == 0);
			endcase
		end
	end

	task automatic send_item(logic [2:0] f, logic [15:0] o, logic [9:0] ix,
			bit typed, resp_t ex);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		func        = f;
		owner_tag   = o;
		frame_index = ix;
		cur_typed   = typed;
		cur_exp     = ex;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		burst_left = 0;
		while (resp_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(ffla_pkg::reg_idx_t r, logic [47:0] d);
		drain();
		cfg_index = r;
		cfg_data  = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic row_t item(logic [2:0] f, logic [15:0] o, logic [9:0] ix);
		row_t r;
		r.kind = ROW_ITEM;
		r.fn = f;
		r.owner = o;
		r.idx = ix;
		r.reg_sel = ffla_pkg::REG_POOL_COUNT;
		r.data = '0;
		r.typed = 1'b0;
		r.exp_resp = '0;
		return r;
	endfunction

	function automatic row_t item_exp(logic [2:0] f, logic [15:0] o, logic [9:0] ix,
			logic st, logic [9:0] fr, logic [10:0] ta, logic [47:0] ad);
		row_t r;
		r = item(f, o, ix);
		r.typed = 1'b1;
		r.exp_resp = '{status: st, frame: fr, tally: ta, phys: ad};
		return r;
	endfunction

	function automatic row_t cfg_row(ffla_pkg::reg_idx_t sel, logic [47:0] d);
		row_t r;
		r = item(ffla_pkg::FN_INIT, 16'd0, 10'd0);
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.data = d;
		return r;
	endfunction

	function automatic logic [15:0] pick_owner();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return none_m;
		if (p < 20) return kern_m;
		if (p < 85) return owner_pool[$urandom_range(0, 3)];
		return 16'($urandom);
	endfunction

	task automatic send_random();
		int n;
		int p;
		int k;
		logic [9:0]  ix;
		logic [15:0] o;
		resp_t none_exp;
		none_exp = '0;
		n = live_n();
		p = $urandom_range(0, 99);
		ix = 10'($urandom);
		o = pick_owner();
		if (p < 3) begin
			send_item(ffla_pkg::FN_INIT, o, ix, 1'b0, none_exp);
		end else if (p < 38) begin
			send_item(ffla_pkg::FN_ALLOC, o, ix, 1'b0, none_exp);
		end else if (p < 63) begin
			if (n > 0 && $urandom_range(0, 9) != 0) begin
				for (k = 0; k < 8; k++) begin
					ix = 10'($urandom_range(0, n - 1));
					if (used_m[ix]) break;
				end
				k = $urandom_range(0, 99);
				o = (k < 70) ? owner_m[ix] : (k < 85) ? kern_m : pick_owner();
			end
			send_item(ffla_pkg::FN_FREE, o, ix, 1'b0, none_exp);
		end else if (p < 73) begin
			send_item(ffla_pkg::FN_COUNT, o, ix, 1'b0, none_exp);
		end else if (p < 78) begin
			send_item(ffla_pkg::FN_RECLAIM, o, ix, 1'b0, none_exp);
		end else if (p < 95) begin
			if ($urandom_range(0, 4) != 0)
				ix = 10'($urandom_range(0, (n + 1 > 1023) ? 1023 : n + 1));
			send_item(ffla_pkg::FN_ADDR, o, ix, 1'b0, none_exp);
		end else begin
			send_item(p[0] ? FN_RSVD7 : FN_RSVD6, o, ix, 1'b0, none_exp);
		end
	endtask

	initial begin
		int pool_sel [8];
		int limit;
		resp_t none_exp;
		none_exp = '0;
		pool_sel = '{12, 1, 40, 2, 5, 1024, 2047, 20};
		errors = 0;
		burst_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = ffla_pkg::FN_INIT;
		owner_tag = '0;
		frame_index = '0;
		cfg_valid = 1'b0;
		cfg_index = ffla_pkg::REG_POOL_COUNT;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_exp = '0;
		pool_n = 11'd1024;
		base_m = '0;
		none_m = 16'd0;
		kern_m = 16'd1;
		head_m = ffla_pkg::FRAMES;
		for (int i = 0; i < ffla_pkg::FRAMES; i++) begin
			used_m[i] = 1'b0;
			owner_m[i] = '0;
			link_m[i] = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'd5, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ADDR, 16'd5, 10'd1023, 1'b0, 0, 0,
			48'd1023 * 48'd4096));
		rows.push_back(item_exp(ffla_pkg::FN_COUNT, 16'd0, 10'd0, 1'b0, 0, 0, 0));
		rows.push_back(item_exp(FN_RSVD6, 16'd1, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(FN_RSVD7, 16'hFFFF, 10'h3FF, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_FREE, 16'd1, 10'd3, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_INIT, 16'd0, 10'd0, 1'b0, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'd5, 10'd0, 1'b0, 10'd0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'hFFFF, 10'd0, 1'b0, 10'd1, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'd0, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_FREE, 16'd7, 10'd1, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_FREE, 16'd1, 10'd1, 1'b0, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'hFFFF, 10'd0, 1'b0, 10'd1, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_COUNT, 16'd5, 10'd0, 1'b0, 0, 11'd1, 0));
		rows.push_back(item_exp(ffla_pkg::FN_RECLAIM, 16'hFFFF, 10'd0, 1'b0, 0, 11'd1, 0));
		rows.push_back(item_exp(ffla_pkg::FN_FREE, 16'd5, 10'd0, 1'b0, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_FREE, 16'd5, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(cfg_row(ffla_pkg::REG_POOL_COUNT, 48'd0));
		rows.push_back(item_exp(ffla_pkg::FN_INIT, 16'd0, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(item_exp(ffla_pkg::FN_ALLOC, 16'd5, 10'd0, 1'b1, 0, 0, 0));
		rows.push_back(cfg_row(ffla_pkg::REG_POOL_COUNT, 48'd2047));
		rows.push_back(cfg_row(ffla_pkg::REG_POOL_BASE, 48'hFFFF_FFFF_FFFF));
		rows.push_back(item_exp(ffla_pkg::FN_ADDR, 16'd0, 10'd1, 1'b0, 0, 0, 48'd4095));
		rows.push_back(item_exp(ffla_pkg::FN_INIT, 16'd0, 10'd0, 1'b0, 0, 0, 0));
		rows.push_back(item(ffla_pkg::FN_ADDR, 16'hFFFF, 10'h3FF));
		rows.push_back(cfg_row(ffla_pkg::REG_OWNER_NONE, 48'hFFFF));
		rows.push_back(cfg_row(ffla_pkg::REG_OWNER_KERNEL, 48'h0));
		rows.push_back(item(ffla_pkg::FN_ALLOC, 16'd0, 10'd0));
		rows.push_back(item(ffla_pkg::FN_FREE, 16'd0, 10'd0));
		rows.push_back(item_exp(ffla_pkg::FN_COUNT, 16'hFFFF, 10'd0, 1'b0, 0, 0, 0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_reg(rows[i].reg_sel, rows[i].data);
			else
				send_item(rows[i].fn, rows[i].owner, rows[i].idx, rows[i].typed,
					rows[i].exp_resp);
		end

		for (int ph = 0; ph < 8; ph++) begin
			for (int k = 0; k < 4; k++)
				owner_pool[k] = (k == 3 && ph[0]) ? 16'hFFFF : 16'($urandom_range(2, 65535));
			write_reg(ffla_pkg::REG_POOL_COUNT, 48'(pool_sel[ph]));
			write_reg(ffla_pkg::REG_POOL_BASE, (ph == 2) ? 48'h0
				: (ph == 3) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
			write_reg(ffla_pkg::REG_OWNER_NONE,
				ph[0] ? 48'($urandom_range(0, 65535)) : 48'h0);
			write_reg(ffla_pkg::REG_OWNER_KERNEL, (ph == 4) ? 48'(none_m)
				: ph[1] ? 48'($urandom_range(0, 65535)) : 48'h1);
			owner_pool[0] = kern_m;
			send_item(ffla_pkg::FN_INIT, 16'd0, 10'd0, 1'b0, none_exp);
			for (int j = 0; j < 86; j++)
				send_random();
		end

		in_valid = 1'b0;
		limit = 0;
		while (resp_q.size() != 0 && limit < 200000) begin
			@(negedge clk);
			limit++;
		end
		repeat (20) @(negedge clk);
		if (resp_q.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", resp_q.size()));
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
sv/ffla_pkg.sv
sv/frame_free_list_allocator_core.sv
dv/tb_frame_free_list_allocator_core.sv
